// File: rtl/fsub_pkg.sv
// Shared constants, codes and types for the first-substring-match block.
package fsub_pkg;

	localparam int PATTERN_MAX_DEF = 32;
	localparam int TEXT_MAX_DEF    = 65536;
	localparam int CH_W            = 8;
	localparam int ACT_W           = 2;
	localparam int STATUS_W        = 2;
	localparam int POS_W           = 16;

	typedef enum logic [ACT_W-1:0] {
		ACT_PATTERN = 2'd0,
		ACT_TEXT    = 2'd1,
		ACT_FINISH  = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_TOO_LONG  = 2'd2
	} status_t;

	// Shift commands and byte for the pattern and text shift lines.
	typedef struct packed {
		logic            pat_shift;
		logic            txt_shift;
		logic [CH_W-1:0] ch;
	} shift_t;

endpackage

// File: rtl/fsub_req_if.sv
// Request channel: one action and one byte per transfer.
interface fsub_req_if;
	logic                        valid;
	logic                        ready;
	logic [fsub_pkg::ACT_W-1:0]  action;
	logic [fsub_pkg::CH_W-1:0]   ch;

	modport source (output valid, output action, output ch, input ready);
	modport sink   (input valid, input action, input ch, output ready);
endinterface

// File: rtl/fsub_rsp_if.sv
// Response channel: search status and match position per transfer.
interface fsub_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [fsub_pkg::STATUS_W-1:0] status;
	logic [fsub_pkg::POS_W-1:0]    position;

	modport source (output valid, output status, output position, input ready);
	modport sink   (input valid, input status, input position, output ready);
endinterface

// File: rtl/first_substring_match.sv
// A finish request passes from the input register to the response register.
// Throughput: one request transfer per cycle while no finish request waits; pattern and text bytes never stall.
// A finish request waits in the input register only while the response register is full.
// The text window compare is one combinational parallel pass over all PATTERN_MAX bytes.
// Reset clears all control state at once; no clearing pass is needed.
module first_substring_match #(
	parameter int PATTERN_MAX = fsub_pkg::PATTERN_MAX_DEF,
	parameter int TEXT_MAX    = fsub_pkg::TEXT_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fsub_req_if.sink   req,
	fsub_rsp_if.source rsp
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int CNT_W = $clog2(TEXT_MAX + 1);
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	// Input register
	logic                        valid_s1;
	logic [fsub_pkg::ACT_W-1:0]  action_s1;
	logic [fsub_pkg::CH_W-1:0]   ch_s1;

	// Search state
	logic [LEN_W-1:0]            len_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        seen_q;
	logic                        ovf_q;
	logic [fsub_pkg::POS_W-1:0]  start_q;

	// Response register
	logic                        rsp_valid_q;
	fsub_pkg::status_t           status_q;
	logic [fsub_pkg::POS_W-1:0]  pos_q;

	logic                        out_free;
	logic                        go_s1;
	logic                        is_pat, is_txt, is_fin;
	logic                        fin_go;
	fsub_pkg::shift_t            ctl;
	logic [PATTERN_MAX-1:0]      hit;
	logic [PATTERN_MAX-1:0]      len_mask;
	logic [CNT_W-1:0]            cnt_next;
	logic [CMP_W-1:0]            start_full;
	logic                        match_now;
	fsub_pkg::status_t           status_d;
	logic [fsub_pkg::POS_W-1:0]  pos_d;

	always_comb begin
		is_pat = 1'b0;
		is_txt = 1'b0;
		is_fin = 1'b0;
		case (fsub_pkg::action_t'(action_s1))
			fsub_pkg::ACT_PATTERN: is_pat = 1'b1;
			fsub_pkg::ACT_TEXT:    is_txt = 1'b1;
			fsub_pkg::ACT_FINISH:  is_fin = 1'b1;
			default:               ;
		endcase
	end

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign go_s1     = valid_s1 && (!is_fin || out_free);
	assign fin_go    = go_s1 && is_fin;
	assign req.ready = !valid_s1 || go_s1;

	// Drop pattern bytes past the store and text bytes past the count limit.
	assign ctl.pat_shift = go_s1 && is_pat && (len_q < LEN_W'(PATTERN_MAX));
	assign ctl.txt_shift = go_s1 && is_txt && (cnt_q < CNT_W'(TEXT_MAX));
	assign ctl.ch        = ch_s1;

	fsub_match #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_match (
		.clk (clk),
		.ctl (ctl),
		.hit (hit)
	);

	for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_mask
		assign len_mask[g] = (LEN_W'(g) < len_q);
	end

	assign cnt_next   = cnt_q + 1'b1;
	assign start_full = CMP_W'(cnt_next) - CMP_W'(len_q);
	assign match_now  = ctl.txt_shift && !seen_q && !ovf_q && (len_q != '0)
		&& (CMP_W'(cnt_next) >= CMP_W'(len_q)) && (&(hit | ~len_mask));

	always_comb begin
		pos_d = '0;
		if (ovf_q) begin
			status_d = fsub_pkg::ST_TOO_LONG;
		end else if (len_q == '0) begin
			status_d = fsub_pkg::ST_FOUND;
		end else if (seen_q) begin
			status_d = fsub_pkg::ST_FOUND;
			pos_d    = start_q;
		end else begin
			status_d = fsub_pkg::ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			len_q       <= '0;
			cnt_q       <= '0;
			seen_q      <= 1'b0;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (fin_go) begin
				len_q       <= '0;
				cnt_q       <= '0;
				seen_q      <= 1'b0;
				ovf_q       <= 1'b0;
				rsp_valid_q <= 1'b1;
			end else begin
				if (ctl.pat_shift) begin
					len_q <= len_q + 1'b1;
				end
				if (go_s1 && is_pat && !ctl.pat_shift) begin
					ovf_q <= 1'b1;
				end
				if (ctl.txt_shift) begin
					cnt_q <= cnt_next;
				end
				if (match_now) begin
					seen_q <= 1'b1;
				end
				if (rsp.ready) begin
					rsp_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			ch_s1     <= req.ch;
		end
		if (match_now) begin
			start_q <= fsub_pkg::POS_W'(start_full);
		end
		if (fin_go) begin
			status_q <= status_d;
			pos_q    <= pos_d;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = status_q;
	assign rsp.position = pos_q;

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(PATTERN_MAX))
		else $error("pattern length beyond store");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == LEN_W'(PATTERN_MAX)))
		else $error("overflow flagged with room in the store");

	a_seen_len: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (len_q != '0))
		else $error("match latched with empty pattern");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TEXT_MAX))
		else $error("text count past its limit");

	a_fin_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (rsp_valid_q && len_q == '0 && cnt_q == '0 && !seen_q && !ovf_q))
		else $error("finish did not load response and clear state");

endmodule

// File: rtl/fsub_match.sv
// Pattern and text shift lines with a full-width parallel byte compare.
module fsub_match #(
	parameter int PATTERN_MAX = fsub_pkg::PATTERN_MAX_DEF
) (
	input  logic                   clk,
	input  fsub_pkg::shift_t       ctl,
	output logic [PATTERN_MAX-1:0] hit
);

	// Both lines hold the newest byte at entry 0, so entry j of one lines up with entry j
	// of the other once the text byte in ctl is shifted in.
	logic [fsub_pkg::CH_W-1:0] pat_q [PATTERN_MAX];
	logic [fsub_pkg::CH_W-1:0] win_q [PATTERN_MAX];

	always_ff @(posedge clk) begin
		if (ctl.pat_shift) begin
			pat_q[0] <= ctl.ch;
			for (int j = 1; j < PATTERN_MAX; j++) begin
				pat_q[j] <= pat_q[j-1];
			end
		end
		if (ctl.txt_shift) begin
			win_q[0] <= ctl.ch;
			for (int j = 1; j < PATTERN_MAX; j++) begin
				win_q[j] <= win_q[j-1];
			end
		end
	end

	// Compare against the window as it stands after the incoming text byte.
	assign hit[0] = (ctl.ch == pat_q[0]);
	for (genvar g = 1; g < PATTERN_MAX; g++) begin : g_cmp
		assign hit[g] = (win_q[g-1] == pat_q[g]);
	end

endmodule

// File: tb/fsub_search_checker.sv
// Checker for the first-substring-match block: tracks the search state and compares responses.
`timescale 1ns / 100ps

module fsub_search_checker #(
	parameter int PATTERN_MAX = fsub_pkg::PATTERN_MAX_DEF,
	parameter int TEXT_MAX    = fsub_pkg::TEXT_MAX_DEF
) (
	input  logic clk,
	input  logic arst_n,
	fsub_req_if  req,
	fsub_rsp_if  rsp,
	output int   errors,
	output int   pending,
	output int   n_found,
	output int   n_missed,
	output int   n_long
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int CNT_W = $clog2(TEXT_MAX + 1);

	typedef struct packed {
		fsub_pkg::status_t          status;
		logic [fsub_pkg::POS_W-1:0] position;
	} outcome_t;

	logic [fsub_pkg::CH_W-1:0]  pat_mem [PATTERN_MAX];
	logic [LEN_W-1:0]           pat_len;
	logic [fsub_pkg::CH_W-1:0]  window [PATTERN_MAX];
	logic [CNT_W-1:0]           txt_cnt;
	logic                       hit;
	logic [fsub_pkg::POS_W-1:0] hit_pos;
	logic                       pat_ovf;
	outcome_t                   outcome_q [$];

	task automatic clear_search();
		for (int i = 0; i < PATTERN_MAX; i++) begin
			pat_mem[i] = '0;
			window[i]  = '0;
		end
		pat_len = '0;
		txt_cnt = '0;
		hit     = 1'b0;
		hit_pos = '0;
		pat_ovf = 1'b0;
	endtask

	// Newest text byte sits at window[0], so the pattern lines up reversed.
	function automatic bit window_holds_pattern();
		for (int k = 0; k < PATTERN_MAX; k++)
			if (k < int'(pat_len) && pat_mem[k] != window[int'(pat_len) - 1 - k])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic predict_step(input logic [fsub_pkg::ACT_W-1:0] act,
			input logic [fsub_pkg::CH_W-1:0] b);
		outcome_t res;
		case (act)
			fsub_pkg::ACT_PATTERN: begin
				if (int'(pat_len) < PATTERN_MAX) begin
					pat_mem[pat_len] = b;
					pat_len++;
				end else begin
					pat_ovf = 1'b1;
				end
			end
			fsub_pkg::ACT_TEXT: begin
				// drop text beyond the counter limit
				if (int'(txt_cnt) < TEXT_MAX) begin
					for (int i = PATTERN_MAX - 1; i > 0; i--)
						window[i] = window[i-1];
					window[0] = b;
					txt_cnt++;
					if (!hit && !pat_ovf && pat_len != 0 && int'(txt_cnt) >= int'(pat_len)
							&& window_holds_pattern()) begin
						hit     = 1'b1;
						hit_pos = fsub_pkg::POS_W'(int'(txt_cnt) - int'(pat_len));
					end
				end
			end
			fsub_pkg::ACT_FINISH: begin
				res.position = '0;
				if (pat_ovf) begin
					res.status = fsub_pkg::ST_TOO_LONG;
				end else if (pat_len == 0) begin
					res.status = fsub_pkg::ST_FOUND;
				end else if (hit) begin
					res.status   = fsub_pkg::ST_FOUND;
					res.position = hit_pos;
				end else begin
					res.status = fsub_pkg::ST_NOT_FOUND;
				end
				outcome_q.push_back(res);
				clear_search();
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			clear_search();
			outcome_q.delete();
			errors   = 0;
			n_found  = 0;
			n_missed = 0;
			n_long   = 0;
		end else begin
			// check the response first so a spurious one cannot meet a fresh expectation
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (outcome_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected response: expected none, actual status %0d position %0d",
						$time, rsp.status, rsp.position);
				end else begin
					want = outcome_q.pop_front();
					if (rsp.status !== want.status) begin
						errors++;
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, rsp.status);
					end
					if (rsp.position !== want.position) begin
						errors++;
						$display("%0t: position mismatch: expected %0d, actual %0d",
							$time, want.position, rsp.position);
					end
					case (want.status)
						fsub_pkg::ST_FOUND:     n_found++;
						fsub_pkg::ST_NOT_FOUND: n_missed++;
						default:                n_long++;
					endcase
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1)
				predict_step(req.action, req.ch);
		end
		pending = outcome_q.size();
	end

endmodule

// File: tb/tb_first_substring_match.sv
// Top of the first-substring-match testbench: clock, reset, request and response traffic, verdict.
`timescale 1ns / 100ps

module tb_first_substring_match;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 4;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int ITEM_TARGET  = 1400;
	localparam int PMAX         = fsub_pkg::PATTERN_MAX_DEF;
	localparam int ACT_W        = fsub_pkg::ACT_W;
	localparam int CH_W         = fsub_pkg::CH_W;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	bit   steady   = 1'b0;
	bit   hold_rsp = 1'b0;
	bit   junk_on  = 1'b0;
	int   sent_items = 0;
	int   errors, pending, n_found, n_missed, n_long;

	fsub_req_if req_if();
	fsub_rsp_if rsp_if();

	first_substring_match DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	fsub_search_checker CHECK (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_if),
		.rsp      (rsp_if),
		.errors   (errors),
		.pending  (pending),
		.n_found  (n_found),
		.n_missed (n_missed),
		.n_long   (n_long)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// One request transfer; called and returning at a falling edge.
	task automatic xfer(input logic [ACT_W-1:0] act, input logic [CH_W-1:0] b);
		while (!steady && $urandom_range(99) < 20) begin
			req_if.valid <= 1'b0;
			req_if.ch    <= CH_W'($urandom);
			@(negedge clk);
		end
		req_if.valid  <= 1'b1;
		req_if.action <= act;
		req_if.ch     <= b;
		@(posedge clk);
		while (req_if.ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_req(input logic [ACT_W-1:0] act, input logic [CH_W-1:0] b);
		if (junk_on && $urandom_range(99) < 3)
			xfer(ACT_UNUSED, CH_W'($urandom));
		xfer(act, b);
		if (act != ACT_UNUSED)
			sent_items++;
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// Well-formed search over a small alphabet so that matches are common.
	task automatic random_search();
		logic [CH_W-1:0] alpha [4];
		logic [CH_W-1:0] pat [$];
		logic [CH_W-1:0] txt [$];
		int n_alpha, plen, tlen, at, split, r;
		for (int i = 0; i < 4; i++)
			alpha[i] = CH_W'($urandom);
		n_alpha = $urandom_range(1, 4);
		r = $urandom_range(99);
		if (r < 65)
			plen = $urandom_range(1, 4);
		else if (r < 82)
			plen = $urandom_range(5, PMAX - 1);
		else if (r < 90)
			plen = PMAX;
		else if (r < 95)
			plen = $urandom_range(PMAX + 1, PMAX + 3);
		else
			plen = 0;
		for (int i = 0; i < plen; i++)
			pat.push_back(alpha[$urandom_range(n_alpha - 1)]);
		tlen = $urandom_range(0, 20) + plen;
		for (int i = 0; i < tlen; i++)
			txt.push_back(alpha[$urandom_range(n_alpha - 1)]);
		if (plen > 0 && plen <= tlen && $urandom_range(1) == 1) begin
			at = $urandom_range(0, tlen - plen);
			for (int k = 0; k < plen; k++)
				txt[at + k] = pat[k];
		end
		// stray byte from outside the alphabet
		if (tlen > 0 && $urandom_range(9) == 0)
			txt[$urandom_range(tlen - 1)] = CH_W'($urandom);
		// hold back the pattern tail until half the text is in
		split = ($urandom_range(99) < 15) ? $urandom_range(0, plen) : plen;
		for (int i = 0; i < split; i++)
			send_req(fsub_pkg::ACT_PATTERN, pat[i]);
		for (int i = 0; i < tlen / 2; i++)
			send_req(fsub_pkg::ACT_TEXT, txt[i]);
		for (int i = split; i < plen; i++)
			send_req(fsub_pkg::ACT_PATTERN, pat[i]);
		for (int i = tlen / 2; i < tlen; i++)
			send_req(fsub_pkg::ACT_TEXT, txt[i]);
		send_req(fsub_pkg::ACT_FINISH, CH_W'($urandom));
	endtask

	task automatic noise_search();
		logic [ACT_W-1:0] act;
		int n;
		n = $urandom_range(0, 12);
		repeat (n) begin
			act = ACT_W'($urandom_range(0, 3));
			if (act == fsub_pkg::ACT_FINISH)
				act = ACT_UNUSED;
			send_req(act, CH_W'($urandom));
		end
		send_req(fsub_pkg::ACT_FINISH, CH_W'($urandom));
	endtask

	// Response side: random stalls, a steady stretch, and one long hold-off on request.
	initial begin
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_rsp = 1'b0;
				rsp_if.ready <= 1'b1;
			end else if (steady) begin
				rsp_if.ready <= 1'b1;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= 20);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [ACT_W+CH_W-1:0] directed_seq [$];
		logic [CH_W-1:0] full_pat [PMAX];
		int search_no;
		directed_seq = '{
			// empty pattern, empty text
			{fsub_pkg::ACT_FINISH, 8'h00},
			// empty pattern with text
			{fsub_pkg::ACT_TEXT, 8'h00}, {fsub_pkg::ACT_TEXT, 8'hFF},
			{fsub_pkg::ACT_FINISH, 8'hFF},
			// zero pattern against zero-filled window before enough text
			{fsub_pkg::ACT_PATTERN, 8'h00}, {fsub_pkg::ACT_PATTERN, 8'h00},
			{fsub_pkg::ACT_TEXT, 8'h00}, {fsub_pkg::ACT_FINISH, 8'h00},
			// pattern byte after text does not revisit earlier text
			{fsub_pkg::ACT_TEXT, 8'h41}, {fsub_pkg::ACT_PATTERN, 8'h41},
			{fsub_pkg::ACT_TEXT, 8'h42}, {fsub_pkg::ACT_FINISH, 8'h00},
			// unused code ignored, 0xFF found at index 1
			{ACT_UNUSED, 8'hFF}, {fsub_pkg::ACT_PATTERN, 8'hFF}, {fsub_pkg::ACT_TEXT, 8'h00},
			{ACT_UNUSED, 8'h00}, {fsub_pkg::ACT_TEXT, 8'hFF}, {fsub_pkg::ACT_FINISH, 8'h00},
			// zero byte is an ordinary character
			{fsub_pkg::ACT_PATTERN, 8'h00}, {fsub_pkg::ACT_TEXT, 8'hFF},
			{fsub_pkg::ACT_TEXT, 8'h00}, {fsub_pkg::ACT_FINISH, 8'h00}
		};

		arst_n = 1'b0;
		req_if.valid  <= 1'b0;
		req_if.action <= fsub_pkg::ACT_PATTERN;
		req_if.ch     <= '0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_seq[i])
			send_req(directed_seq[i][ACT_W+CH_W-1:CH_W], directed_seq[i][CH_W-1:0]);

		// full-length pattern after three leading bytes
		for (int i = 0; i < PMAX; i++)
			full_pat[i] = CH_W'($urandom);
		for (int i = 0; i < PMAX; i++)
			send_req(fsub_pkg::ACT_PATTERN, full_pat[i]);
		repeat (3)
			send_req(fsub_pkg::ACT_TEXT, CH_W'($urandom));
		for (int i = 0; i < PMAX; i++)
			send_req(fsub_pkg::ACT_TEXT, full_pat[i]);
		send_req(fsub_pkg::ACT_FINISH, '0);

		// one byte too many for the store; matching text must not count
		for (int i = 0; i < PMAX; i++)
			send_req(fsub_pkg::ACT_PATTERN, full_pat[i]);
		send_req(fsub_pkg::ACT_PATTERN, 8'hA5);
		for (int i = 0; i < PMAX; i++)
			send_req(fsub_pkg::ACT_TEXT, full_pat[i]);
		send_req(fsub_pkg::ACT_FINISH, '0);

		// long response stall with finishes queued behind it
		wait_drained();
		steady   = 1'b1;
		hold_rsp = 1'b1;
		repeat (8) begin
			send_req(fsub_pkg::ACT_PATTERN, CH_W'($urandom_range(1)));
			send_req(fsub_pkg::ACT_TEXT, CH_W'($urandom_range(1)));
			send_req(fsub_pkg::ACT_FINISH, '0);
		end
		wait_drained();
		steady = 1'b0;

		junk_on   = 1'b1;
		search_no = 0;
		while (sent_items < ITEM_TARGET) begin
			steady = (search_no >= 25 && search_no < 40);
			if ($urandom_range(99) < 12)
				noise_search();
			else
				random_search();
			if ($urandom_range(99) < 5)
				wait_drained();
			search_no++;
		end
		steady  = 1'b0;
		junk_on = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES)
			@(negedge clk);
		$display("covered %0d request transfers, %0d searches: %0d found, %0d not found, %0d overflow",
			sent_items, n_found + n_missed + n_long, n_found, n_missed, n_long);
		$display("included edge searches, full and overflowing patterns, long stall");
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
